[sv/scf_pkg.sv]
package scf_pkg;

    // Line length, sine resolution and sample width.
    localparam int DEPTH        = 2048;
    localparam int SINE_ENTRIES = 1024;
    localparam int SAMPLE_BITS  = 24;

    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SINE_BITS = $clog2(SINE_ENTRIES);

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [18:0] DELAY_ONE_RST   = 19'd86016;
    localparam logic [18:0] DELAY_TWO_RST   = 19'd172032;
    localparam logic [30:0] PHASE_STEP_RST  = 31'd44739;
    localparam logic [31:0] PHASE_OFFS_RST  = 32'd1073741824;
    localparam logic [14:0] FB_GAIN_RST     = 15'd0;
    localparam logic [15:0] WET_GAIN_RST    = 16'd16384;

    // Datapath operations, one per cycle, issued in this order per channel.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_IDLE    = 5'd0;
    localparam logic [OP_W-1:0] OP_ANGLE   = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL_TT  = 5'd2;
    localparam logic [OP_W-1:0] OP_SAVE_T2 = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL_T2K = 5'd4;
    localparam logic [OP_W-1:0] OP_INNER   = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_T2I = 5'd6;
    localparam logic [OP_W-1:0] OP_OUTER   = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_TZ  = 5'd8;
    localparam logic [OP_W-1:0] OP_SINE    = 5'd9;
    localparam logic [OP_W-1:0] OP_MUL_D1  = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL_D2  = 5'd11;
    localparam logic [OP_W-1:0] OP_DSUM    = 5'd12;
    localparam logic [OP_W-1:0] OP_DCLAMP  = 5'd13;
    localparam logic [OP_W-1:0] OP_ADDR_FB = 5'd14;
    localparam logic [OP_W-1:0] OP_WRITE   = 5'd15;
    localparam logic [OP_W-1:0] OP_MUL_X0  = 5'd16;
    localparam logic [OP_W-1:0] OP_MUL_X1  = 5'd17;
    localparam logic [OP_W-1:0] OP_WET     = 5'd18;
    localparam logic [OP_W-1:0] OP_MUL_DRY = 5'd19;
    localparam logic [OP_W-1:0] OP_MUL_WET = 5'd20;
    localparam logic [OP_W-1:0] OP_MIX     = 5'd21;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic [18:0] delay_one;
        logic [18:0] delay_two;
        logic [30:0] phase_step;
        logic [31:0] right_phase_offset;
        logic [14:0] feedback_gain;
        logic [15:0] wet_gain;
    } t_cfg;

    typedef struct packed {
        logic            start;
        logic            clear;
        logic            load_out;
        logic            chan;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic wi_last;
    } t_stat;

endpackage

[sv/scf_regs.sv]
module scf_regs import scf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    localparam logic [2:0] REG_DELAY_ONE  = 3'd0;
    localparam logic [2:0] REG_DELAY_TWO  = 3'd1;
    localparam logic [2:0] REG_PHASE_STEP = 3'd2;
    localparam logic [2:0] REG_PHASE_OFFS = 3'd3;
    localparam logic [2:0] REG_FB_GAIN    = 3'd4;
    localparam logic [2:0] REG_WET_GAIN   = 3'd5;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_one          <= DELAY_ONE_RST;
            r_cfg.delay_two          <= DELAY_TWO_RST;
            r_cfg.phase_step         <= PHASE_STEP_RST;
            r_cfg.right_phase_offset <= PHASE_OFFS_RST;
            r_cfg.feedback_gain      <= FB_GAIN_RST;
            r_cfg.wet_gain           <= WET_GAIN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DELAY_ONE:  r_cfg.delay_one          <= pwdata[18:0];
                REG_DELAY_TWO:  r_cfg.delay_two          <= pwdata[18:0];
                REG_PHASE_STEP: r_cfg.phase_step         <= pwdata[30:0];
                REG_PHASE_OFFS: r_cfg.right_phase_offset <= pwdata;
                REG_FB_GAIN:    r_cfg.feedback_gain      <= pwdata[14:0];
                REG_WET_GAIN:   r_cfg.wet_gain           <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DELAY_ONE:  prdata = PDATA_W'(r_cfg.delay_one);
            REG_DELAY_TWO:  prdata = PDATA_W'(r_cfg.delay_two);
            REG_PHASE_STEP: prdata = PDATA_W'(r_cfg.phase_step);
            REG_PHASE_OFFS: prdata = PDATA_W'(r_cfg.right_phase_offset);
            REG_FB_GAIN:    prdata = PDATA_W'(r_cfg.feedback_gain);
            REG_WET_GAIN:   prdata = PDATA_W'(r_cfg.wet_gain);
            default:        prdata = '0;
        endcase
    end

endmodule

[sv/scf_ctrl.sv]
module scf_ctrl import scf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;
    logic            r_chan, n_chan;
    logic            r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_chan  = r_chan;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.wi_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_RUN;
                    n_op        = OP_ANGLE;
                    n_chan      = 1'b0;
                end
            end
            ST_RUN: begin
                o_cmd.op   = r_op;
                o_cmd.chan = r_chan;
                if (r_op == OP_MIX) begin
                    if (!r_chan) begin
                        n_chan = 1'b1;
                        n_op   = OP_ANGLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_op = r_op + 1'b1;
                end
            end
            ST_DONE: begin
                // The finished pair waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_op        <= OP_IDLE;
            r_chan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_chan      <= n_chan;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_RUN && r_op == OP_ANGLE && !r_chan))
        else $error("request did not start the left channel sequence");

    a_end_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_op == OP_MIX && r_chan) |=> (r_state == ST_DONE))
        else $error("right channel mix did not finish the request");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

[sv/scf_dpath.sv]
module scf_dpath import scf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_item o_out
);

    localparam int MUL_A_W = ((SAMPLE_BITS > 19) ? SAMPLE_BITS : 19) + 1;
    localparam int MUL_B_W = 18;
    localparam int PW      = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PW + 1;
    localparam int DW      = ((ADDR_W + 8) > 19) ? (ADDR_W + 8) : 19;

    localparam logic [15:0]   K_T2    = 16'd2320;
    localparam logic [16:0]   K_INNER = 17'd21023;
    localparam logic [16:0]   K_OUTER = 17'd51472;
    localparam logic [DW-1:0] D_MIN   = DW'(256);
    localparam logic [DW-1:0] D_MAX   = DW'((DEPTH - 2) * 256);
    localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(DEPTH);

    localparam longint LINE_LIM_L = longint'(1) << (SAMPLE_BITS - 2);
    localparam longint SMAX_L     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [PW-1:0]    W_HI = PW'(LINE_LIM_L);
    localparam logic signed [PW-1:0]    W_LO = PW'(-LINE_LIM_L);
    localparam logic signed [ACC_W-1:0] S_HI = ACC_W'(SMAX_L);
    localparam logic signed [ACC_W-1:0] S_LO = ACC_W'(-SMAX_L - 1);

    // State that survives between requests.
    logic [31:0]                   r_phase;
    logic [ADDR_W-1:0]             r_wi;
    logic signed [SAMPLE_BITS-1:0] r_fb_l, r_fb_r;

    // Working registers.
    t_in_item                      r_in;
    logic [15:0]                   r_t, r_t2, r_v, r_u;
    logic [1:0]                    r_quad;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic [ADDR_W-1:0]             r_n, r_i0, r_i1;
    logic [7:0]                    r_f;
    logic signed [SAMPLE_BITS-1:0] r_wet, r_res_l, r_res_r;
    t_out_item                     r_out;

    logic signed [SAMPLE_BITS-1:0] r_left_mem  [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_right_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_l0, r_rd_l1, r_rd_r0, r_rd_r1;

    logic [31:0]                   ph;
    logic [SINE_BITS-1:0]          entry;
    logic [15:0]                   ang;
    logic [14:0]                   rmir;
    logic [16:0]                   val_raw;
    logic [15:0]                   val, u_new;
    logic [DW-1:0]                 d_raw, d_c;
    logic [ADDR_W:0]               wi_x, n_x, n1_x;
    logic [ADDR_W-1:0]             i0_new, i1_new;
    logic [15:0]                   wg_eff, dry_g;
    logic signed [SAMPLE_BITS-1:0] dry, fb, x0, x1;
    logic signed [MUL_A_W-1:0]     a_op;
    logic signed [MUL_B_W-1:0]     b_op;
    logic signed [PW-1:0]          w_sum;
    logic signed [SAMPLE_BITS-1:0] w_clamp, wdata;
    logic signed [ACC_W-1:0]       acc_sum, wet_sh, mix_sh;
    logic signed [SAMPLE_BITS-1:0] mix_sat;
    logic                          we_l, we_r, rd_en;

    always_comb begin
        dry = i_cmd.chan ? r_in.right_in : r_in.left_in;
        fb  = i_cmd.chan ? r_fb_r : r_fb_l;
        x0  = i_cmd.chan ? r_rd_r0 : r_rd_l0;
        x1  = i_cmd.chan ? r_rd_r1 : r_rd_l1;

        // Quarter-wave folding of the table angle.
        ph    = i_cmd.chan ? (r_phase + i_cfg.right_phase_offset) : r_phase;
        entry = ph[31 -: SINE_BITS];
        ang   = 16'(entry) << (16 - SINE_BITS);
        rmir  = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};

        val_raw = r_prod[31:15];
        val     = (val_raw > 17'd32767) ? 16'd32767 : val_raw[15:0];
        u_new   = r_quad[1] ? 16'(17'd32768 - {1'b0, val}) : 16'(17'd32768 + {1'b0, val});

        d_raw = DW'(r_acc[34:16]);
        if (d_raw < D_MIN) begin
            d_c = D_MIN;
        end else if (d_raw > D_MAX) begin
            d_c = D_MAX;
        end else begin
            d_c = d_raw;
        end

        // Read taps behind the write pointer, wrapped modulo the line length.
        wi_x = {1'b0, r_wi};
        n_x  = {1'b0, r_n};
        n1_x = n_x + 1'b1;
        i1_new = (wi_x >= n_x)  ? ADDR_W'(wi_x - n_x)  : ADDR_W'(wi_x + DEPTH_X - n_x);
        i0_new = (wi_x >= n1_x) ? ADDR_W'(wi_x - n1_x) : ADDR_W'(wi_x + DEPTH_X - n1_x);

        wg_eff = (i_cfg.wet_gain > 16'd32768) ? 16'd32768 : i_cfg.wet_gain;
        dry_g  = 16'(17'd32768 - {1'b0, wg_eff});

        case (i_cmd.op)
            OP_MUL_TT: begin
                a_op = $signed(MUL_A_W'(r_t));
                b_op = $signed(MUL_B_W'(r_t));
            end
            OP_MUL_T2K: begin
                a_op = $signed(MUL_A_W'(r_t2));
                b_op = $signed(MUL_B_W'(K_T2));
            end
            OP_MUL_T2I: begin
                a_op = $signed(MUL_A_W'(r_t2));
                b_op = $signed(MUL_B_W'(r_v));
            end
            OP_MUL_TZ: begin
                a_op = $signed(MUL_A_W'(r_t));
                b_op = $signed(MUL_B_W'(r_v));
            end
            OP_MUL_D1: begin
                a_op = $signed(MUL_A_W'(i_cfg.delay_one));
                b_op = $signed(MUL_B_W'(r_v));
            end
            OP_MUL_D2: begin
                a_op = $signed(MUL_A_W'(i_cfg.delay_two));
                b_op = $signed(MUL_B_W'(r_u));
            end
            OP_ADDR_FB: begin
                a_op = MUL_A_W'(fb);
                b_op = $signed(MUL_B_W'(i_cfg.feedback_gain));
            end
            OP_MUL_X0: begin
                a_op = MUL_A_W'(x0);
                b_op = $signed(MUL_B_W'(r_f));
            end
            OP_MUL_X1: begin
                a_op = MUL_A_W'(x1);
                b_op = $signed(MUL_B_W'(9'd256 - {1'b0, r_f}));
            end
            OP_MUL_DRY: begin
                a_op = MUL_A_W'(dry);
                b_op = $signed(MUL_B_W'(dry_g));
            end
            OP_MUL_WET: begin
                a_op = MUL_A_W'(r_wet);
                b_op = $signed(MUL_B_W'(wg_eff));
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase

        w_sum = PW'(dry) + (r_prod >>> 15);
        if (w_sum > W_HI) begin
            w_clamp = SAMPLE_BITS'(W_HI);
        end else if (w_sum < W_LO) begin
            w_clamp = SAMPLE_BITS'(W_LO);
        end else begin
            w_clamp = SAMPLE_BITS'(w_sum);
        end

        acc_sum = r_acc + ACC_W'(r_prod);
        wet_sh  = acc_sum >>> 8;
        mix_sh  = acc_sum >>> 15;
        if (mix_sh > S_HI) begin
            mix_sat = SAMPLE_BITS'(S_HI);
        end else if (mix_sh < S_LO) begin
            mix_sat = SAMPLE_BITS'(S_LO);
        end else begin
            mix_sat = SAMPLE_BITS'(mix_sh);
        end

        we_l  = i_cmd.clear || (i_cmd.op == OP_WRITE && !i_cmd.chan);
        we_r  = i_cmd.clear || (i_cmd.op == OP_WRITE && i_cmd.chan);
        rd_en = (i_cmd.op == OP_WRITE);
        wdata = i_cmd.clear ? '0 : w_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_wi    <= '0;
            r_fb_l  <= '0;
            r_fb_r  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_phase <= r_phase + {1'b0, i_cfg.phase_step};
            end
            if (i_cmd.clear || i_cmd.load_out) begin
                r_wi <= (r_wi == ADDR_W'(DEPTH - 1)) ? '0 : r_wi + 1'b1;
            end
            if (i_cmd.op == OP_WET) begin
                if (i_cmd.chan) begin
                    r_fb_r <= SAMPLE_BITS'(wet_sh);
                end else begin
                    r_fb_l <= SAMPLE_BITS'(wet_sh);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= a_op * b_op;
        if (i_cmd.start) begin
            r_in <= i_in;
        end
        if (i_cmd.load_out) begin
            r_out.left_out  <= r_res_l;
            r_out.right_out <= r_res_r;
        end
        case (i_cmd.op)
            OP_ANGLE: begin
                r_t    <= {rmir, 1'b0};
                r_quad <= ang[15:14];
            end
            OP_SAVE_T2: r_t2 <= r_prod[30:15];
            OP_INNER:   r_v  <= 16'(K_INNER - r_prod[31:15]);
            OP_OUTER:   r_v  <= 16'(K_OUTER - r_prod[31:15]);
            OP_SINE: begin
                r_u <= u_new;
                r_v <= 16'(17'd0 - {1'b0, u_new});
            end
            OP_MUL_D2:  r_acc <= ACC_W'(r_prod);
            OP_DSUM:    r_acc <= acc_sum;
            OP_DCLAMP: begin
                r_n <= d_c[8 +: ADDR_W];
                r_f <= d_c[7:0];
            end
            OP_ADDR_FB: begin
                r_i0 <= i0_new;
                r_i1 <= i1_new;
            end
            OP_MUL_X1:  r_acc <= ACC_W'(r_prod);
            OP_WET:     r_wet <= SAMPLE_BITS'(wet_sh);
            OP_MUL_WET: r_acc <= ACC_W'(r_prod);
            OP_MIX: begin
                if (i_cmd.chan) begin
                    r_res_r <= mix_sat;
                end else begin
                    r_res_l <= mix_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_l) begin
            r_left_mem[r_wi] <= wdata;
        end
        if (rd_en) begin
            r_rd_l0 <= r_left_mem[r_i0];
            r_rd_l1 <= r_left_mem[r_i1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_r) begin
            r_right_mem[r_wi] <= wdata;
        end
        if (rd_en) begin
            r_rd_r0 <= r_right_mem[r_i0];
            r_rd_r1 <= r_right_mem[r_i1];
        end
    end

    assign o_stat.wi_last = (r_wi == ADDR_W'(DEPTH - 1));
    assign o_out          = r_out;

`ifndef SYNTH
    a_taps_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WRITE) |-> (r_i0 != r_wi && r_i1 != r_wi))
        else $error("read tap collides with the write pointer");

    a_delay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ADDR_FB) |-> (r_n != '0))
        else $error("integer delay below one sample");
`endif

endmodule

[sv/stereo_chorus_flanger_unit.sv]
// Stereo chorus/flanger: each request carries one Q3.20 stereo sample and
// yields one saturated Q3.20 stereo sample. A sine LFO sweeps each channel's
// delay between delay_one and delay_two; the right channel's LFO is shifted
// by right_phase_offset. A request runs 21 steps of a shared 25x18 multiplier
// datapath for each channel, then a hand-over state that loads the pair into
// the output register; only then is the block ready for the next request.
// A new request is taken while the previous result still waits in that
// register; the hand-over of the next pair stalls only while that register
// is still full. After reset the block zeroes both delay lines, one entry
// per cycle, before its first request; registers may be written meanwhile.
module stereo_chorus_flanger_unit import scf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    scf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    scf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    scf_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

[test/tb_stereo_chorus_flanger_unit.sv]
module tb_stereo_chorus_flanger_unit import scf_pkg::*; ();

    // Register indexes on the configuration port; each register sits at 4 * index.
    localparam int REG_DELAY_ONE  = 0;
    localparam int REG_DELAY_TWO  = 1;
    localparam int REG_PHASE_STEP = 2;
    localparam int REG_PHASE_OFFS = 3;
    localparam int REG_FB_GAIN    = 4;
    localparam int REG_WET_GAIN   = 5;
    localparam int REG_SPARE_A    = 6;
    localparam int REG_SPARE_B    = 7;

    localparam longint LINE_LIMIT = 64'sd1 << (SAMPLE_BITS - 2);
    localparam longint OUT_MAX    = (64'sd1 << (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN    = -(64'sd1 << (SAMPLE_BITS - 1));

    localparam int PHASE_ITEMS = 72;
    localparam int LONG_HOLD   = 400;

    class chorus_scoreboard;
        logic [18:0] delay_one;
        logic [18:0] delay_two;
        logic [30:0] phase_step;
        logic [31:0] phase_offs;
        logic [14:0] fb_gain;
        logic [15:0] wet_gain;
        logic [31:0] lfo_phase;
        int          write_ptr;
        int          taps[2][DEPTH];
        int          wet_hist[2];
        t_out_item   expected_pairs[$];
        int          errors;

        function new();
            delay_one  = DELAY_ONE_RST;
            delay_two  = DELAY_TWO_RST;
            phase_step = PHASE_STEP_RST;
            phase_offs = PHASE_OFFS_RST;
            fb_gain    = FB_GAIN_RST;
            wet_gain   = WET_GAIN_RST;
            lfo_phase  = '0;
            write_ptr  = 0;
            for (int c = 0; c < 2; c++) begin
                wet_hist[c] = 0;
                for (int k = 0; k < DEPTH; k++) taps[c][k] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] value);
            case (idx)
                REG_DELAY_ONE:  delay_one  = value[18:0];
                REG_DELAY_TWO:  delay_two  = value[18:0];
                REG_PHASE_STEP: phase_step = value[30:0];
                REG_PHASE_OFFS: phase_offs = value;
                REG_FB_GAIN:    fb_gain    = value[14:0];
                REG_WET_GAIN:   wet_gain   = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        // Polynomial sine in Q1.15, folded by quadrant.
        function longint sweep_sine(logic [31:0] phase);
            longint entry, ang, quad, r, t, t2, inner, v;
            entry = (longint'(phase) * SINE_ENTRIES) >>> 32;
            ang   = ((entry * 65536) / SINE_ENTRIES) & 64'hFFFF;
            quad  = ang >>> 14;
            r     = ang & 16383;
            if (quad % 2 == 1) r = 16384 - r;
            t     = 2 * r;
            t2    = (t * t) >>> 15;
            inner = 21023 - ((t2 * 2320) >>> 15);
            v     = (t * (51472 - ((t2 * inner) >>> 15))) >>> 15;
            if (v > 32767) v = 32767;
            return (quad >= 2) ? -v : v;
        endfunction

        function longint process_channel(int ch, longint dry, logic [31:0] phase);
            longint u, d, n, f, w, wet, wg, mix;
            int     i0, i1;
            u = 32768 + sweep_sine(phase);
            d = (longint'(delay_one) * (65536 - u) + longint'(delay_two) * u) >>> 16;
            if (d < 256) d = 256;
            if (d > (DEPTH - 2) * 256) d = (DEPTH - 2) * 256;
            n = d >>> 8;
            f = d & 255;

            // The new sample goes into the line before the tap is read.
            w = dry + ((longint'(wet_hist[ch]) * longint'(fb_gain)) >>> 15);
            if (w > LINE_LIMIT) w = LINE_LIMIT;
            if (w < -LINE_LIMIT) w = -LINE_LIMIT;
            taps[ch][write_ptr] = int'(w);

            if (f == 0) begin
                i0  = int'((write_ptr + DEPTH - n) % DEPTH);
                wet = taps[ch][i0];
            end else begin
                i0  = int'((write_ptr + DEPTH - n - 1) % DEPTH);
                i1  = (i0 + 1) % DEPTH;
                wet = (longint'(taps[ch][i0]) * f + longint'(taps[ch][i1]) * (256 - f)) >>> 8;
            end
            wet_hist[ch] = int'(wet);

            wg  = (wet_gain > 32768) ? 32768 : longint'(wet_gain);
            mix = (dry * (32768 - wg) + wet * wg) >>> 15;
            if (mix > OUT_MAX) mix = OUT_MAX;
            if (mix < OUT_MIN) mix = OUT_MIN;
            return mix;
        endfunction

        function void take_sample(t_in_item s);
            logic [31:0] right_phase;
            longint      l, r;
            t_out_item   e;
            lfo_phase   = lfo_phase + {1'b0, phase_step};
            right_phase = lfo_phase + phase_offs;
            l = process_channel(0, longint'(s.left_in), lfo_phase);
            r = process_channel(1, longint'(s.right_in), right_phase);
            write_ptr = (write_ptr + 1) % DEPTH;
            e.left_out  = l[SAMPLE_BITS-1:0];
            e.right_out = r[SAMPLE_BITS-1:0];
            expected_pairs.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            if (errors < 40) $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_pair(t_out_item y);
            t_out_item e;
            if (expected_pairs.size() == 0) begin
                report("result with no request pending, left_out", y.left_out, 0);
            end else begin
                e = expected_pairs.pop_front();
                if (y.left_out !== e.left_out) report("left_out", y.left_out, e.left_out);
                if (y.right_out !== e.right_out) report("right_out", y.right_out, e.right_out);
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out;

    chorus_scoreboard sb = new();
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    stereo_chorus_flanger_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_pair(o_out);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    initial begin : result_side
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && rx_idle_on && $urandom_range(0, 9) < 3) begin
                hold = gap_length();
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(int idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_settings(logic [31:0] d1, logic [31:0] d2, logic [31:0] step,
                                  logic [31:0] offs, logic [31:0] fb, logic [31:0] wet);
        write_reg(REG_DELAY_ONE, d1);
        write_reg(REG_DELAY_TWO, d2);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_PHASE_OFFS, offs);
        write_reg(REG_FB_GAIN, fb);
        write_reg(REG_WET_GAIN, wet);
    endtask

    task automatic send_sample(t_in_item s);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 9) < 3) gap = gap_length();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_sample(s);
    endtask

    task automatic send_pair(int l, int r);
        t_in_item s;
        s.left_in  = l[SAMPLE_BITS-1:0];
        s.right_in = r[SAMPLE_BITS-1:0];
        send_sample(s);
    endtask

    // Stops offering requests and waits for every outstanding result.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic int random_level();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 8388607 : -8388608;
            1:       return int'($urandom_range(0, 4095)) - 2048;
            2:       return $urandom_range(0, 1) ? 4194304 : -4194304;
            default: return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] d1, d2, step, fb, wet;
        // Short delays keep the taps inside the part of the line already written.
        d1   = ($urandom_range(0, 9) < 7) ? $urandom_range(256, 51200) : $urandom_range(0, 19'h7FFFF);
        d2   = ($urandom_range(0, 9) < 7) ? $urandom_range(256, 51200) : $urandom_range(0, 19'h7FFFF);
        step = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1 << 26) : $urandom;
        fb   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 31130) : $urandom_range(0, 32767);
        wet  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 32768) : $urandom_range(0, 65535);
        write_settings(d1, d2, step, $urandom, fb, wet);
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings with the sample extremes.
        send_pair(8388607, -8388608);
        send_pair(-8388608, 8388607);
        send_pair(0, 0);
        send_pair(-1, 1);
        send_pair(4194304, -4194304);
        send_pair(8388607, 8388607);
        send_pair(-8388608, -8388608);
        drain_results();

        // All ones everywhere: delays past the line end, wet gain above full,
        // feedback above 0.95, and writes to addresses past the register list.
        write_settings('1, '1, '1, '1, '1, '1);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        send_pair(8388607, 8388607);
        send_pair(-8388608, -8388608);
        send_pair(8388607, -8388608);
        send_pair(0, 0);
        send_pair(-1, -1);
        send_pair(1, -2);
        drain_results();

        // Zero delays clamp to one sample; loud input drives the write clamp.
        write_settings(0, 0, 0, 0, 31130, 32768);
        send_pair(8388607, 8388607);
        send_pair(8388607, -8388608);
        send_pair(-8388608, -8388608);
        send_pair(4194305, -4194305);
        send_pair(0, 0);
        drain_results();

        // Reversed delays, fully dry, LFO stepping a quarter turn per request.
        write_settings(523776, 256, 32'h4000_0000, 32'h8000_0000, 0, 0);
        send_pair(123456, -654321);
        send_pair(-8388608, 8388607);
        send_pair(7, -7);
        send_pair(8388607, 0);
        send_pair(0, -8388608);
        drain_results();

        for (int p = 0; p < 6; p++) begin
            random_settings();
            tx_idle_on = (p != 0) && (p != 5);
            rx_idle_on = (p != 0) && (p != 4);
            if (p == 1) long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2) drain_results();
                send_pair(random_level(), random_level());
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[stereo_chorus_flanger_unit.f]
sv/scf_pkg.sv
sv/scf_regs.sv
sv/scf_ctrl.sv
sv/scf_dpath.sv
sv/stereo_chorus_flanger_unit.sv
test/tb_stereo_chorus_flanger_unit.sv
